### hw/rtl/i8mm_pkg.sv
// ----------------------------------------------------------------------------
// i8mm_pkg
// Shared widths, codes and types of the int8 matrix multiply tile.
// ----------------------------------------------------------------------------
package i8mm_pkg;

    // tile limits
    localparam int MAX_COLS   = 32;
    localparam int MAX_DEPTH  = 256;
    localparam int MAX_ROWS   = 64;
    localparam int LANES      = 4;

    localparam int GROUPS_MAX = (MAX_DEPTH + LANES - 1) / LANES;

    // field and counter widths
    localparam int BYTE_W     = 8;
    localparam int PROD_W     = 2 * BYTE_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int SUM_W      = 24;
    localparam int B_W        = LANES * BYTE_W;
    localparam int GRP_W      = $clog2(GROUPS_MAX);
    localparam int NG_W       = GRP_W + 1;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int M_W        = 7;
    localparam int N_W        = 6;
    localparam int K_W        = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_M_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_N_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K_DEPTH = 2'd2;

    // item commands
    localparam logic CMD_LOAD_B   = 1'b0;
    localparam logic CMD_STREAM_A = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_EMIT
    } state_t;

    typedef logic signed [BYTE_W-1:0] byte_t;

    // control shared by all column lanes
    typedef struct packed {
        logic                     wr_en;
        logic [GRP_W-1:0]         wr_group;
        logic                     rd_en;
        logic [GRP_W-1:0]         rd_group;
        logic                     mac_en;
        logic                     clr;
        logic [LANES-1:0][BYTE_W-1:0] a_bytes;
    } lane_ctl_t;

endpackage

### hw/rtl/i8mm_if.sv
// ----------------------------------------------------------------------------
// i8mm channel interfaces
// Item, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface i8mm_item_if;
    import i8mm_pkg::*;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [GRP_W-1:0]    group_index;
    logic [COL_W-1:0]    column;
    logic signed [7:0]   lane0;
    logic signed [7:0]   lane1;
    logic signed [7:0]   lane2;
    logic signed [7:0]   lane3;

    modport source (output valid, cmd, group_index, column, lane0, lane1, lane2, lane3,
                    input ready);
    modport sink (input valid, cmd, group_index, column, lane0, lane1, lane2, lane3,
                  output ready);
endinterface

interface i8mm_result_if;
    import i8mm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [COL_W-1:0]        col_index;
    logic signed [SUM_W-1:0] sum;
    logic                    last_in_row;
    logic                    last_in_matrix;

    modport source (output valid, col_index, sum, last_in_row, last_in_matrix,
                    input ready);
    modport sink (input valid, col_index, sum, last_in_row, last_in_matrix,
                  output ready);
endinterface

interface i8mm_cfg_if;
    import i8mm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/int8_matrix_multiply_tile.sv
// ----------------------------------------------------------------------------
// int8_matrix_multiply_tile
// Signed int8 matrix multiply C = A x B with 24-bit accumulation, one
// column lane per column of B, and a drain stage that emits a row of C.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  item     in   cmd, group_index, column, lane0..lane3
//  result   out  col_index, sum, last_in_row, last_in_matrix
//  cfg      in   index, data (m_rows, n_cols, k_depth)
//
//  a B load beat is written into the selected lane's store
//  an A beat: lane store read, then the lane multiply-adds
//  the last A beat of a row is followed by n_cols result beats, one per cycle
//  unless stalled, read out of the lane accumulators via the output register
//  output stalls hold the drain; item is taken only while nothing is at work
//  reset clears the counters and accumulators; the B store is not cleared
// ----------------------------------------------------------------------------
module int8_matrix_multiply_tile (
    input  logic           clk,
    input  logic           rst_n,
    i8mm_item_if.sink      item,
    i8mm_result_if.source  result,
    i8mm_cfg_if.sink       cfg
);
    import i8mm_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [M_W-1:0]      m_reg;
    logic [N_W-1:0]      n_reg;
    logic [K_W-1:0]      k_reg;
    logic [M_W-1:0]      m_clamp;
    logic [N_W-1:0]      n_clamp;
    logic [K_W-1:0]      k_clamp;
    logic [GRP_W-1:0]    gc_reg;
    logic [GRP_W-1:0]    gc_next;
    logic [ROW_W-1:0]    rc_reg;
    logic [ROW_W-1:0]    rc_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic                last_row_reg;
    logic                last_row_next;
    logic [LANES-1:0][BYTE_W-1:0] a_reg;
    logic [LANES-1:0][BYTE_W-1:0] a_masked;
    byte_t               in_lane [LANES];
    logic [K_W:0]        k_plus;
    logic [NG_W-1:0]     ngroups;
    logic                row_end;
    logic                last_row;
    logic                accept_item;
    logic                load_b;
    logic                start_a;
    logic                out_free;
    logic                out_load;
    logic                col_last;
    logic                out_valid_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic                out_lir_reg;
    logic                out_lim_reg;
    logic [MAX_COLS-1:0] wr_sel;
    logic [MAX_COLS-1:0] active;
    logic signed [SUM_W-1:0] acc_lane [MAX_COLS];
    lane_ctl_t           ctl;

    // register writes, saturated into the legal range
    assign cfg.ready = 1'b1;

    always_comb
    begin
        m_clamp = cfg.data[M_W-1:0];
        if (m_clamp == '0)
        begin
            m_clamp = M_W'(1);
        end
        else if (m_clamp > M_W'(MAX_ROWS))
        begin
            m_clamp = M_W'(MAX_ROWS);
        end
        n_clamp = cfg.data[N_W-1:0];
        if (n_clamp == '0)
        begin
            n_clamp = N_W'(1);
        end
        else if (n_clamp > N_W'(MAX_COLS))
        begin
            n_clamp = N_W'(MAX_COLS);
        end
        k_clamp = cfg.data[K_W-1:0];
        if (k_clamp == '0)
        begin
            k_clamp = K_W'(1);
        end
        else if (k_clamp > K_W'(MAX_DEPTH))
        begin
            k_clamp = K_W'(MAX_DEPTH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= M_W'(32);
            n_reg <= N_W'(32);
            k_reg <= K_W'(130);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_M_ROWS:  m_reg <= m_clamp;
                REG_N_COLS:  n_reg <= n_clamp;
                REG_K_DEPTH: k_reg <= k_clamp;
                default:     ;
            endcase
        end
    end

    // group count and end-of-row / end-of-matrix tests
    assign k_plus   = {1'b0, k_reg} + (K_W+1)'(LANES - 1);
    assign ngroups  = k_plus[K_W-1:2];
    assign row_end  = ({1'b0, gc_reg} + NG_W'(1)) >= ngroups;
    assign last_row = ({1'b0, rc_reg} + M_W'(1)) >= m_reg;

    // item handshake
    assign item.ready  = (state_reg == ST_IDLE);
    assign accept_item = item.valid && item.ready;
    assign load_b      = accept_item && (item.cmd == CMD_LOAD_B);
    assign start_a     = accept_item && (item.cmd == CMD_STREAM_A);

    // zero the A lanes that fall past k_depth
    assign in_lane[0] = item.lane0;
    assign in_lane[1] = item.lane1;
    assign in_lane[2] = item.lane2;
    assign in_lane[3] = item.lane3;

    always_comb
    begin
        for (int r = 0; r < LANES; r++)
        begin
            a_masked[r] = ({1'b0, gc_reg, 2'(r)} < k_reg) ? in_lane[r] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_a)
        begin
            a_reg <= a_masked;
        end
    end

    // output register of the drain stage
    assign out_free = !out_valid_reg || result.ready;
    assign col_last = ({1'b0, col_reg} == (n_reg - N_W'(1)));

    // sequencer: next state and counters
    always_comb
    begin
        state_next    = state_reg;
        gc_next       = gc_reg;
        rc_next       = rc_reg;
        col_next      = col_reg;
        last_row_next = last_row_reg;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_a)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (row_end)
                begin
                    gc_next       = '0;
                    last_row_next = last_row;
                    rc_next       = last_row ? '0 : rc_reg + ROW_W'(1);
                    col_next      = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    gc_next    = gc_reg + GRP_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    col_next = col_reg + COL_W'(1);
                    if (col_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            gc_reg       <= '0;
            rc_reg       <= '0;
            col_reg      <= '0;
            last_row_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            gc_reg       <= gc_next;
            rc_reg       <= rc_next;
            col_reg      <= col_next;
            last_row_reg <= last_row_next;
        end
    end

    // lane control
    always_comb
    begin
        ctl.wr_en    = load_b;
        ctl.wr_group = item.group_index;
        ctl.rd_en    = start_a;
        ctl.rd_group = gc_reg;
        ctl.mac_en   = (state_reg == ST_MAC);
        ctl.clr      = out_load && col_last;
        ctl.a_bytes  = a_reg;
    end

    // column lanes
    for (genvar j = 0; j < MAX_COLS; j++)
    begin : g_lane
        assign wr_sel[j] = (item.column == COL_W'(j));
        assign active[j] = (n_reg > N_W'(j));

        i8mm_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .wr_sel  (wr_sel[j]),
            .active  (active[j]),
            .wr_data ({item.lane3, item.lane2, item.lane1, item.lane0}),
            .acc     (acc_lane[j])
        );
    end

    // drain: pick one lane accumulator per result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_col_reg <= col_reg;
            out_sum_reg <= acc_lane[col_reg];
            out_lir_reg <= col_last;
            out_lim_reg <= col_last && last_row_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.col_index      = out_col_reg;
    assign result.sum            = out_sum_reg;
    assign result.last_in_row    = out_lir_reg;
    assign result.last_in_matrix = out_lim_reg;

    // checks
    a_lim_implies_lir: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (!result.last_in_matrix || result.last_in_row))
        else $error("last_in_matrix without last_in_row");

    a_a_beat_to_mac: assert property (@(posedge clk) disable iff (!rst_n)
        start_a |=> (state_reg == ST_MAC))
        else $error("A beat did not reach the multiply-add cycle");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.clr) |=> (acc_lane[0] == '0) && (state_reg == ST_IDLE))
        else $error("accumulators not cleared after a row drain");

    a_drain_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_IDLE) |=> result.last_in_row)
        else $error("row drain ended without a last_in_row beat");

endmodule

### hw/rtl/i8mm_ram.sv
// ----------------------------------------------------------------------------
// i8mm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module i8mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/i8mm_lane.sv
// ----------------------------------------------------------------------------
// i8mm_lane
// One column of C: holds its B column, forms the 4-way dot product of an
// A group with its B group and adds it into the column accumulator.
// ----------------------------------------------------------------------------
module i8mm_lane (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  i8mm_pkg::lane_ctl_t                  ctl,
    input  logic                                 wr_sel,
    input  logic                                 active,
    input  logic [i8mm_pkg::B_W-1:0]             wr_data,
    output logic signed [i8mm_pkg::SUM_W-1:0]    acc
);
    import i8mm_pkg::*;

    logic [B_W-1:0]           b_word;
    logic signed [PROD_W-1:0] prod [LANES];
    logic signed [DOT_W-1:0]  dot;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;

    // B column store, one word per k-group
    i8mm_ram #(
        .WIDTH (B_W),
        .DEPTH (GROUPS_MAX)
    ) u_bram (
        .clk     (clk),
        .wr_en   (ctl.wr_en & wr_sel),
        .wr_addr (ctl.wr_group),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (ctl.rd_group),
        .rd_data (b_word)
    );

    // four signed byte products and their sum
    always_comb
    begin
        dot = '0;
        for (int r = 0; r < LANES; r++)
        begin
            prod[r] = $signed(ctl.a_bytes[r]) * $signed(b_word[r*BYTE_W +: BYTE_W]);
            dot     = dot + DOT_W'(prod[r]);
        end
    end

    // accumulate, wrapping at the sum width
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clr)
        begin
            acc_next = '0;
        end
        else if (ctl.mac_en && active)
        begin
            acc_next = acc_reg + SUM_W'(dot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### tb/tb_int8_matrix_multiply_tile.sv
// ----------------------------------------------------------------------------
// tb_int8_matrix_multiply_tile
// Self-checking bench for the int8 matrix multiply tile. B groups are loaded
// and A groups streamed over the item channel, and registers are written
// over the register channel. A cycle-free copy of the tile's arithmetic
// predicts every C element. Each result beat is checked field by field
// against the oldest predicted element. Directed checks come first, then
// random traffic under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_int8_matrix_multiply_tile;
    import i8mm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned DRAIN_PAUSE = 4;

    // kinds of lane data
    localparam int QK_RAND = 0;
    localparam int QK_NEG  = 1;
    localparam int QK_POS  = 2;
    localparam int QK_EDGE = 3;

    typedef logic [LANES-1:0][BYTE_W-1:0] quad_t;

    localparam quad_t ALL_NEG = {LANES{8'h80}};
    localparam quad_t ALL_POS = {LANES{8'h7F}};

    typedef struct packed {
        logic             cmd;
        logic [GRP_W-1:0] grp;
        logic [COL_W-1:0] col;
        quad_t            lanes;
    } tile_beat_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [SUM_W-1:0] acc_sum;
        logic             row_end;
        logic             mat_end;
    } c_elem_t;

    logic clk;
    logic rst_n;

    i8mm_item_if   item_bus ();
    i8mm_result_if res_bus ();
    i8mm_cfg_if    cfg_bus ();

    // bench state
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned err_count = 0;
    int unsigned n_sent    = 0;
    int unsigned quiet_cycles;
    c_elem_t     exp_q [$];
    c_elem_t     chk_want;

    // predictor state
    logic [B_W-1:0]   b_mem [GROUPS_MAX][MAX_COLS];
    logic [SUM_W-1:0] acc_m [MAX_COLS];
    logic [GRP_W-1:0] pred_gc;
    logic [ROW_W-1:0] pred_rc;
    logic [M_W-1:0]   m_raw;
    logic [N_W-1:0]   n_raw;
    logic [K_W-1:0]   k_raw;

    int8_matrix_multiply_tile u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (res_bus),
        .cfg    (cfg_bus)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    function automatic int unsigned clamp_u(input int unsigned v, input int unsigned hi);
        if (v < 1)
        begin
            return 1;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // register write as seen by the predictor
    function automatic void model_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_M_ROWS:  m_raw = val[M_W-1:0];
            REG_N_COLS:  n_raw = val[N_W-1:0];
            REG_K_DEPTH: k_raw = val[K_W-1:0];
            default:     ;
        endcase
    endfunction

    // one accepted item beat as seen by the predictor
    function automatic void predict_beat(input tile_beat_t b);
        int unsigned    m_use;
        int unsigned    n_use;
        int unsigned    k_use;
        int unsigned    ng;
        int             a_val [LANES];
        int             dot;
        logic [B_W-1:0] w;
        logic           lrow;
        c_elem_t        e;

        if (b.cmd == CMD_LOAD_B)
        begin
            b_mem[b.grp][b.col] = b.lanes;
            return;
        end

        m_use = clamp_u(int'(m_raw), MAX_ROWS);
        n_use = clamp_u(int'(n_raw), MAX_COLS);
        k_use = clamp_u(int'(k_raw), MAX_DEPTH);
        ng    = (k_use + 3) / 4;

        // lanes past the inner dimension count as zero
        for (int r = 0; r < LANES; r++)
        begin
            a_val[r] = ((int'(pred_gc) * LANES + r) < int'(k_use)) ?
                       int'($signed(b.lanes[r])) : 0;
        end

        // dot product into every active column
        for (int j = 0; j < int'(n_use); j++)
        begin
            w   = b_mem[pred_gc][COL_W'(j)];
            dot = 0;
            for (int r = 0; r < LANES; r++)
            begin
                dot = dot + a_val[r] * int'($signed(w[r*BYTE_W +: BYTE_W]));
            end
            acc_m[COL_W'(j)] = acc_m[COL_W'(j)] + SUM_W'(dot);
        end

        // end of row: one element per column, then clear
        if (int'(pred_gc) + 1 >= int'(ng))
        begin
            lrow = (int'(pred_rc) + 1 >= int'(m_use));
            for (int j = 0; j < int'(n_use); j++)
            begin
                e.col     = COL_W'(j);
                e.acc_sum = acc_m[COL_W'(j)];
                e.row_end = (j + 1 == int'(n_use));
                e.mat_end = e.row_end && lrow;
                exp_q.push_back(e);
            end
            for (int j = 0; j < MAX_COLS; j++)
            begin
                acc_m[COL_W'(j)] = '0;
            end
            pred_gc = '0;
            pred_rc = lrow ? '0 : pred_rc + ROW_W'(1);
        end
        else
        begin
            pred_gc = pred_gc + GRP_W'(1);
        end
    endfunction

    function automatic quad_t pick_quad(input int kind);
        quad_t q;
        case (kind)
            QK_NEG:  q = ALL_NEG;
            QK_POS:  q = ALL_POS;
            QK_EDGE:
            begin
                for (int r = 0; r < LANES; r++)
                begin
                    q[r] = ($urandom_range(1) != 0) ? 8'h80 : 8'h7F;
                end
            end
            default:
            begin
                for (int r = 0; r < LANES; r++)
                begin
                    q[r] = BYTE_W'($urandom);
                end
            end
        endcase
        return q;
    endfunction

    function automatic tile_beat_t make_b(input int grp, input int col, input quad_t q);
        tile_beat_t b;
        b.cmd   = CMD_LOAD_B;
        b.grp   = GRP_W'(grp);
        b.col   = COL_W'(col);
        b.lanes = q;
        return b;
    endfunction

    // group and column are don't-care on an A beat
    function automatic tile_beat_t make_a(input quad_t q);
        tile_beat_t b;
        b.cmd   = CMD_STREAM_A;
        b.grp   = GRP_W'($urandom);
        b.col   = COL_W'($urandom);
        b.lanes = q;
        return b;
    endfunction

    // send one item beat; starts and ends at a falling edge with valid low
    task automatic send_beat(input tile_beat_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
        end
        item_bus.cmd         = b.cmd;
        item_bus.group_index = b.grp;
        item_bus.column      = b.col;
        item_bus.lane0       = b.lanes[0];
        item_bus.lane1       = b.lanes[1];
        item_bus.lane2       = b.lanes[2];
        item_bus.lane3       = b.lanes[3];
        item_bus.valid       = 1'b1;
        @(posedge clk);
        while (!item_bus.ready)
        begin
            @(posedge clk);
        end
        predict_beat(b);
        n_sent++;
        @(negedge clk);
        item_bus.valid = 1'b0;
    endtask

    // wait until every predicted result is out and the tile is idle
    task automatic wait_drained;
        while (exp_q.size() != 0 || !item_bus.ready)
        begin
            @(negedge clk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        cfg_bus.valid = 1'b1;
        @(posedge clk);
        while (!cfg_bus.ready)
        begin
            @(posedge clk);
        end
        model_cfg(idx, val);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic load_b(input int n_use, input int ng, input int kind);
        for (int g = 0; g < ng; g++)
        begin
            for (int j = 0; j < n_use; j++)
            begin
                send_beat(make_b(g, j, pick_quad(kind)));
            end
        end
    endtask

    task automatic stream_rows(input int rows, input int ng, input int kind);
        for (int i = 0; i < rows; i++)
        begin
            for (int g = 0; g < ng; g++)
            begin
                send_beat(make_a(pick_quad(kind)));
            end
        end
    endtask

    // row count left at its reset value
    task automatic test_default_rows;
        cfg_write(REG_N_COLS, CFG_DATA_W'(2));
        cfg_write(REG_K_DEPTH, CFG_DATA_W'(8));
        load_b(2, 2, QK_RAND);
        stream_rows(1, 2, QK_RAND);
        wait_drained();
    endtask

    // zero, oversized and unknown register writes
    task automatic test_register_saturation;
        // zero in every register counts as one
        cfg_write(REG_M_ROWS, '0);
        cfg_write(REG_N_COLS, '0);
        cfg_write(REG_K_DEPTH, '0);
        load_b(1, 1, QK_RAND);
        stream_rows(2, 1, QK_EDGE);
        // unknown index ignored, column count clamps to the maximum
        cfg_write(REG_SPARE, '1);
        cfg_write(REG_N_COLS, CFG_DATA_W'(63));
        load_b(MAX_COLS, 1, QK_RAND);
        stream_rows(1, 1, QK_RAND);
        // row count clamps, bits above the field dropped
        cfg_write(REG_N_COLS, CFG_DATA_W'(1));
        cfg_write(REG_M_ROWS, CFG_DATA_W'('h1C1));
        stream_rows(MAX_ROWS, 1, QK_RAND);
        wait_drained();
    endtask

    // deepest row of most negative bytes gives the largest sum
    task automatic test_extreme_sum;
        cfg_write(REG_M_ROWS, CFG_DATA_W'(1));
        cfg_write(REG_N_COLS, CFG_DATA_W'(1));
        cfg_write(REG_K_DEPTH, CFG_DATA_W'('h1FF));
        load_b(1, GROUPS_MAX, QK_NEG);
        stream_rows(1, GROUPS_MAX, QK_NEG);
        wait_drained();
    endtask

    // depth not a multiple of four, sender pauses between rows
    task automatic test_depth_padding;
        cfg_write(REG_M_ROWS, CFG_DATA_W'(2));
        cfg_write(REG_N_COLS, CFG_DATA_W'(3));
        cfg_write(REG_K_DEPTH, CFG_DATA_W'(5));
        load_b(3, 2, QK_POS);
        stream_rows(1, 2, QK_EDGE);
        wait_drained();
        repeat (DRAIN_PAUSE) @(negedge clk);
        stream_rows(1, 2, QK_EDGE);
        wait_drained();
    endtask

    // random shapes and traffic under one idle and stall mix
    task automatic test_random_mix(input int unsigned idle_p, input int unsigned stall_p,
                                   input int unsigned budget);
        int unsigned n_use;
        int unsigned k_use;
        int unsigned m_use;
        int unsigned ng;
        int unsigned start;

        n_use = $urandom_range(3, 1);
        k_use = $urandom_range(12, 1);
        m_use = $urandom_range(2, 1);
        ng    = (k_use + 3) / 4;
        cfg_write(REG_M_ROWS, CFG_DATA_W'(m_use));
        cfg_write(REG_N_COLS, CFG_DATA_W'(n_use));
        cfg_write(REG_K_DEPTH, CFG_DATA_W'(k_use));
        idle_pct  = idle_p;
        stall_pct = stall_p;
        start     = n_sent;
        load_b(n_use, ng, QK_RAND);
        while (n_sent - start < budget)
        begin
            // occasional reload of one column's B group between rows
            if ($urandom_range(3) == 0)
            begin
                send_beat(make_b($urandom_range(ng - 1), $urandom_range(n_use - 1),
                                 pick_quad(QK_RAND)));
            end
            stream_rows(1, ng, ($urandom_range(1) != 0) ? QK_EDGE : QK_RAND);
            // sometimes let every result come out first
            if ($urandom_range(4) == 0)
            begin
                wait_drained();
                repeat (DRAIN_PAUSE) @(negedge clk);
            end
        end
        wait_drained();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        res_bus.ready = ($urandom_range(99) >= stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (exp_q.size() == 0)
            begin
                report_mismatch("unexpected result col_index", int'(res_bus.col_index), -1);
            end
            else
            begin
                chk_want = exp_q.pop_front();
                if (res_bus.col_index !== chk_want.col)
                begin
                    report_mismatch("col_index", int'(res_bus.col_index), int'(chk_want.col));
                end
                if (res_bus.sum !== chk_want.acc_sum)
                begin
                    report_mismatch("sum", int'(res_bus.sum), int'($signed(chk_want.acc_sum)));
                end
                if (res_bus.last_in_row !== chk_want.row_end)
                begin
                    report_mismatch("last_in_row", int'(res_bus.last_in_row),
                                    int'(chk_want.row_end));
                end
                if (res_bus.last_in_matrix !== chk_want.mat_end)
                begin
                    report_mismatch("last_in_matrix", int'(res_bus.last_in_matrix),
                                    int'(chk_want.mat_end));
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) ||
            (res_bus.valid && res_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n                = 1'b0;
        item_bus.valid       = 1'b0;
        item_bus.cmd         = CMD_LOAD_B;
        item_bus.group_index = '0;
        item_bus.column      = '0;
        item_bus.lane0       = '0;
        item_bus.lane1       = '0;
        item_bus.lane2       = '0;
        item_bus.lane3       = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = '0;
        cfg_bus.data         = '0;
        m_raw                = M_W'(32);
        n_raw                = N_W'(32);
        k_raw                = K_W'(130);
        pred_gc              = '0;
        pred_rc              = '0;
        for (int j = 0; j < MAX_COLS; j++)
        begin
            acc_m[COL_W'(j)] = '0;
        end

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_default_rows();
        test_register_saturation();
        test_extreme_sum();
        test_depth_padding();
        test_random_mix(0, 0, 27);
        test_random_mix(58, 0, 27);
        test_random_mix(0, 58, 27);
        test_random_mix(6, 6, 27);
        wait_drained();

        if (err_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
